/* src/akks_pkg.sv */
// shared types and constants for the akima knot slope block
// no dependencies
`default_nettype none
package akks_pkg;

	localparam logic [1:0] CFG_MODE = 2'd0;
	localparam logic [1:0] CFG_EPS  = 2'd1;

	localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
	localparam logic [31:0] S32_MIN = 32'h8000_0000;

	typedef struct packed {
		logic latch_in;
		logic start_seg;
		logic shift;
		logic start_c13;
		logic start_c02;
		logic ak_mul1;
		logic ak_mul2;
		logic ak_add;
		logic ak_fin;
		logic load_zero;
		logic load_seg0;
		logic load_seg1;
		logic out_load;
		logic out_end;
	} cmd_t;

	typedef struct packed {
		logic op_done;
		logic slope_mode;
	} st_t;

endpackage
`default_nettype wire

/* src/akks_div.sv */
// restoring divider, one quotient bit per cycle, saturated signed result
// uses akks_pkg
`default_nettype none
module akks_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dvd,
	input  wire logic [32:0] dvs,
	input  wire logic        neg,
	output logic             done,
	output logic [31:0]      quot
);
	import akks_pkg::*;

	logic [32:0] rem_q;
	logic [63:0] dvd_q;
	logic [32:0] dvs_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [33:0] trial;
	logic [33:0] diff;
	logic        qbit;

	assign trial = {rem_q, dvd_q[63]};
	assign diff  = trial - {1'b0, dvs_q};
	assign qbit  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd63;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dvd;
			dvs_q <= dvs;
			neg_q <= neg;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[32:0] : trial[32:0];
			dvd_q <= {dvd_q[62:0], qbit};
		end
	end

	// quotient ends up in dvd_q
	always_comb begin
		if (neg_q) begin
			if (dvd_q[63:31] != 33'd0) quot = S32_MIN;
			else quot = ~dvd_q[31:0] + 32'd1;
		end else begin
			if (dvd_q[63:31] != 33'd0) quot = S32_MAX;
			else quot = dvd_q[31:0];
		end
	end

	assign done = done_q;
endmodule
`default_nettype wire

/* src/akks_dp.sv */
// datapath: knot window, segment slopes, akima weights, output register
// uses akks_pkg and akks_div
`default_nettype none
module akks_dp #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire akks_pkg::cmd_t cmd,
	output akks_pkg::st_t      st,
	input  wire logic [63:0]   in_data,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [15:0]   cfg_data,
	output logic [31:0]        slope,
	output logic               slope_end,
	output logic               slope_zero
);
	import akks_pkg::*;

	logic [31:0] in_x_q, in_y_q;
	logic [31:0] wx_q [4];
	logic [31:0] wy_q [4];
	logic [31:0] sg_q [3];
	logic        sz_q [3];
	logic [31:0] old_sg_q;
	logic        old_z_q;
	logic [31:0] res_q;
	logic        resz_q;
	logic        zdone_q;
	logic signed [63:0] p1_q, p2_q, num_q;
	logic        mode_q;
	logic [15:0] eps_q;
	logic [31:0] slope_q;
	logic        end_q, zero_q;

	logic [32:0] dy, dx, mag_dy, mag_dx;
	logic        dxz, qstart;
	logic [63:0] dy_sh;
	logic [32:0] d1, d0, n1, n0, nor_v;
	logic [30:0] w1, w0;
	logic        cond, orz;
	logic [30:0] mul_a;
	logic [31:0] mul_b;
	logic signed [63:0] prod;
	logic [63:0] num_mag;
	logic [31:0] den;
	logic [32:0] avg_s, avg_t;
	logic        div_start, div_done, div_neg;
	logic [63:0] div_dvd;
	logic [32:0] div_dvs;
	logic [31:0] div_q;
	logic [31:0] zsat;

	always_comb begin
		if (cmd.start_c13) begin
			dy = {wy_q[1][31], wy_q[1]} - {wy_q[3][31], wy_q[3]};
			dx = {wx_q[1][31], wx_q[1]} - {wx_q[3][31], wx_q[3]};
		end else if (cmd.start_c02) begin
			dy = {wy_q[0][31], wy_q[0]} - {wy_q[2][31], wy_q[2]};
			dx = {wx_q[0][31], wx_q[0]} - {wx_q[2][31], wx_q[2]};
		end else begin
			dy = {in_y_q[31], in_y_q} - {wy_q[0][31], wy_q[0]};
			dx = {in_x_q[31], in_x_q} - {wx_q[0][31], wx_q[0]};
		end
	end

	assign mag_dy = dy[32] ? (~dy + 33'd1) : dy;
	assign mag_dx = dx[32] ? (~dx + 33'd1) : dx;
	assign dxz    = (dx == 33'd0);
	assign qstart = cmd.start_seg | cmd.start_c13 | cmd.start_c02;
	assign dy_sh  = {31'd0, mag_dy} << FRAC_BITS;

	always_comb begin
		if (dy == 33'd0) zsat = 32'd0;
		else if (dy[32]) zsat = S32_MIN;
		else zsat = S32_MAX;
	end

	// akima weights from the current segment slopes
	assign d1 = {sg_q[0][31], sg_q[0]} - {sg_q[1][31], sg_q[1]};
	assign d0 = {sg_q[2][31], sg_q[2]} - {old_sg_q[31], old_sg_q};
	assign n1 = d1[32] ? (~d1 + 33'd1) : d1;
	assign n0 = d0[32] ? (~d0 + 33'd1) : d0;
	assign cond  = (n0 > {17'd0, eps_q}) || (n1 > {17'd0, eps_q});
	assign orz   = sz_q[0] | sz_q[1] | sz_q[2] | old_z_q;
	assign nor_v = n0 | n1;

	always_comb begin
		if (nor_v[32]) begin
			w1 = n1[32:2];
			w0 = n0[32:2];
		end else if (nor_v[31]) begin
			w1 = n1[31:1];
			w0 = n0[31:1];
		end else begin
			w1 = n1[30:0];
			w0 = n0[30:0];
		end
	end

	assign mul_a = cmd.ak_mul2 ? w0 : w1;
	assign mul_b = cmd.ak_mul2 ? sg_q[1] : sg_q[2];
	assign prod  = $signed({1'b0, mul_a}) * $signed(mul_b);

	assign num_mag = num_q[63] ? (~num_q + 64'd1) : num_q;
	assign den     = {1'b0, w0} + {1'b0, w1};

	assign avg_s = {sg_q[1][31], sg_q[1]} + {sg_q[2][31], sg_q[2]};
	assign avg_t = avg_s + {32'd0, avg_s[32]};

	assign div_start = (qstart & ~dxz) | (cmd.ak_fin & cond);
	assign div_dvd   = cmd.ak_fin ? num_mag : dy_sh;
	assign div_dvs   = cmd.ak_fin ? {1'b0, den} : mag_dx;
	assign div_neg   = cmd.ak_fin ? num_q[63] : (dy[32] ^ dx[32]);

	akks_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.dvd    (div_dvd),
		.dvs    (div_dvs),
		.neg    (div_neg),
		.done   (div_done),
		.quot   (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			eps_q    <= 16'd1;
			zdone_q  <= 1'b0;
			old_sg_q <= '0;
			old_z_q  <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				wx_q[i] <= '0;
				wy_q[i] <= '0;
			end
			for (int i = 0; i < 3; i++) begin
				sg_q[i] <= '0;
				sz_q[i] <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MODE: mode_q <= cfg_data[0];
					CFG_EPS:  eps_q  <= cfg_data;
					default: ;
				endcase
			end
			zdone_q <= (qstart & dxz) | (cmd.ak_fin & ~cond);
			if (cmd.shift) begin
				for (int i = 3; i > 0; i--) begin
					wx_q[i] <= wx_q[i-1];
					wy_q[i] <= wy_q[i-1];
				end
				wx_q[0]  <= in_x_q;
				wy_q[0]  <= in_y_q;
				old_sg_q <= sg_q[2];
				old_z_q  <= sz_q[2];
				for (int i = 2; i > 0; i--) begin
					sg_q[i] <= sg_q[i-1];
					sz_q[i] <= sz_q[i-1];
				end
				sg_q[0] <= res_q;
				sz_q[0] <= resz_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			in_x_q <= in_data[31:0];
			in_y_q <= in_data[63:32];
		end
		if (cmd.ak_mul1) p1_q <= prod;
		if (cmd.ak_mul2) p2_q <= prod;
		if (cmd.ak_add) num_q <= p1_q + p2_q;

		if (div_done) begin
			res_q <= div_q;
		end else if (qstart) begin
			resz_q <= dxz;
			if (dxz) res_q <= zsat;
		end else if (cmd.ak_fin) begin
			resz_q <= orz;
			if (!cond) res_q <= avg_t[32:1];
		end else if (cmd.load_zero) begin
			res_q  <= '0;
			resz_q <= 1'b0;
		end else if (cmd.load_seg0) begin
			res_q  <= sg_q[0];
			resz_q <= sz_q[0];
		end else if (cmd.load_seg1) begin
			res_q  <= sg_q[1];
			resz_q <= sz_q[1];
		end

		if (cmd.out_load) begin
			slope_q <= res_q;
			end_q   <= cmd.out_end;
			zero_q  <= resz_q;
		end
	end

	assign st.op_done    = div_done | zdone_q;
	assign st.slope_mode = mode_q;
	assign slope      = slope_q;
	assign slope_end  = end_q;
	assign slope_zero = zero_q;
endmodule
`default_nettype wire

/* src/akks_ctrl.sv */
// controller: sequences the per-knot divisions and result items
// uses akks_pkg
`default_nettype none
module akks_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic          in_last,
	output logic               out_valid,
	input  wire logic          out_ready,
	output akks_pkg::cmd_t     cmd,
	input  wire akks_pkg::st_t st
);
	import akks_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SEG   = 4'd1;
	localparam logic [3:0] S_SEGW  = 4'd2;
	localparam logic [3:0] S_SHIFT = 4'd3;
	localparam logic [3:0] S_DISP  = 4'd4;
	localparam logic [3:0] S_OLDW  = 4'd5;
	localparam logic [3:0] S_AK1   = 4'd6;
	localparam logic [3:0] S_AK2   = 4'd7;
	localparam logic [3:0] S_AK3   = 4'd8;
	localparam logic [3:0] S_AK4   = 4'd9;
	localparam logic [3:0] S_C02   = 4'd10;
	localparam logic [3:0] S_C02W  = 4'd11;
	localparam logic [3:0] S_LAST  = 4'd12;
	localparam logic [3:0] S_EMIT  = 4'd13;
	localparam logic [3:0] S_DONE  = 4'd14;

	logic [3:0] state_q, state_n;
	logic [3:0] ret_q, ret_n;
	logic       end_q, end_n;
	logic [2:0] cnt_q;
	logic       fin_q;
	logic       ovalid_q;
	logic       out_free;
	logic [3:0] after_old;

	assign out_free  = ~ovalid_q | out_ready;
	assign after_old = fin_q ? S_C02 : S_DONE;

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		ret_n   = ret_q;
		end_n   = end_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_n      = S_SEG;
				end
			end
			S_SEG: begin
				if (cnt_q != 3'd0) begin
					cmd.start_seg = 1'b1;
					state_n       = S_SEGW;
				end else begin
					cmd.load_zero = 1'b1;
					state_n       = S_SHIFT;
				end
			end
			S_SEGW: begin
				if (st.op_done) state_n = S_SHIFT;
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				state_n   = S_DISP;
			end
			S_DISP: begin
				if (fin_q && cnt_q == 3'd0) begin
					// lone knot
					cmd.load_zero = 1'b1;
					end_n   = 1'b1;
					ret_n   = S_DONE;
					state_n = S_EMIT;
				end else if (fin_q && cnt_q == 3'd1) begin
					cmd.load_seg0 = 1'b1;
					end_n   = 1'b0;
					ret_n   = S_LAST;
					state_n = S_EMIT;
				end else if (cnt_q == 3'd2) begin
					cmd.load_seg1 = 1'b1;
					end_n   = 1'b0;
					ret_n   = after_old;
					state_n = S_EMIT;
				end else if (cnt_q == 3'd3 || (cnt_q == 3'd4 && st.slope_mode)) begin
					cmd.start_c13 = 1'b1;
					state_n       = S_OLDW;
				end else if (cnt_q == 3'd4) begin
					state_n = S_AK1;
				end else begin
					state_n = S_DONE;
				end
			end
			S_OLDW: begin
				if (st.op_done) begin
					end_n   = 1'b0;
					ret_n   = after_old;
					state_n = S_EMIT;
				end
			end
			S_AK1: begin
				cmd.ak_mul1 = 1'b1;
				state_n     = S_AK2;
			end
			S_AK2: begin
				cmd.ak_mul2 = 1'b1;
				state_n     = S_AK3;
			end
			S_AK3: begin
				cmd.ak_add = 1'b1;
				state_n    = S_AK4;
			end
			S_AK4: begin
				cmd.ak_fin = 1'b1;
				state_n    = S_OLDW;
			end
			S_C02: begin
				cmd.start_c02 = 1'b1;
				state_n       = S_C02W;
			end
			S_C02W: begin
				if (st.op_done) begin
					end_n   = 1'b0;
					ret_n   = S_LAST;
					state_n = S_EMIT;
				end
			end
			S_LAST: begin
				cmd.load_seg0 = 1'b1;
				end_n   = 1'b1;
				ret_n   = S_DONE;
				state_n = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_end  = end_q;
					state_n      = ret_q;
				end
			end
			S_DONE: begin
				state_n = S_IDLE;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ret_q    <= S_IDLE;
			end_q    <= 1'b0;
			cnt_q    <= '0;
			fin_q    <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			ret_q   <= ret_n;
			end_q   <= end_n;
			if (cmd.latch_in) fin_q <= in_last;
			if (state_q == S_DONE) begin
				if (fin_q) cnt_q <= '0;
				else if (cnt_q != 3'd4) cnt_q <= cnt_q + 3'd1;
			end
			if (cmd.out_load) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ovalid_q;
endmodule
`default_nettype wire

/* src/akima_knot_slopes.sv */
// top level of the akima knot slope block
// uses akks_pkg, akks_ctrl, akks_dp (with akks_div)
//
// One knot is taken at a time. Its slope items come out through a one-item
// output register, so the next knot can be taken while a slope still waits.
// The first knot of a curve needs no divide. Every later knot needs one divide
// for its segment slope, unless its x step is zero. A knot that also produces
// an older slope may take a second divide. A final knot takes up to three
// divides. The divider is shared and bit-serial, and a stalled output
// delays the sequence. The slope of knot j-2 appears once knot j has arrived,
// and the final knot flushes the rest. Configuration writes are always taken.
`default_nettype none
module akima_knot_slopes #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // knot_x [31:0], knot_y [63:32]
	input  wire logic        s_tlast,   // final_knot
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // knot_slope [31:0]
	output logic             m_tlast,   // curve_end
	output logic             m_tuser,   // zero_interval
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import akks_pkg::*;

	cmd_t cmd;
	st_t  st;

	assign cfg_ready = 1'b1;

	akks_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_last   (s_tlast),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.st        (st)
	);

	akks_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.in_data    (s_tdata),
		.cfg_we     (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.slope      (m_tdata),
		.slope_end  (m_tlast),
		.slope_zero (m_tuser)
	);
endmodule
`default_nettype wire

/* src/akks_chk.sv */
// port-level checks for akima_knot_slopes, bound to the top level
// depends on akima_knot_slopes ports only
`default_nettype none
module akks_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic        m_tlast,
	input wire logic        m_tuser
);
	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("result item changed while stalled");

	// one knot at a time: ready drops after an item is taken
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready stayed high after accept");

	// idle block stays ready until an item arrives
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready && !s_tvalid |=> s_tready)
		else $error("input ready dropped while idle");
endmodule

bind akima_knot_slopes akks_chk u_akks_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
`default_nettype wire

/* test/akks_checker.sv */
// slope checker for akima_knot_slopes: watches the knot, slope and register channels
// depends on akks_pkg for register indexes and saturation limits
`timescale 1ns / 1ps
`default_nettype none
module akks_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [63:0] s_tdata,
	input  wire logic        s_tlast,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [31:0] m_tdata,
	input  wire logic        m_tlast,
	input  wire logic        m_tuser,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	output int               fail_count,
	output int               pending,
	output int               slopes_seen
);
	import akks_pkg::*;

	typedef struct packed {
		logic [31:0] slope;
		logic        last;
		logic        zero;
	} slope_item_t;

	slope_item_t expected_slopes[$];

	logic        mode_q;
	logic [15:0] eps_q;
	longint      kx[4], ky[4], seg[3], seg_old;
	logic        segz[3], segz_old;
	int          knot_count;

	function automatic longint sat_div(longint dy, longint dx, output logic zero);
		longint q;
		zero = 1'b0;
		if (dx == 0) begin
			zero = 1'b1;
			if (dy > 0) return longint'(S32_MAX);
			if (dy < 0) return -64'sd2147483648;
			return 0;
		end
		q = ((dy < 0 ? -dy : dy) <<< 16) / (dx < 0 ? -dx : dx);
		if ((dy < 0) != (dx < 0)) begin
			return q >= 64'sd2147483648 ? -64'sd2147483648 : -q;
		end
		return q > 64'sd2147483647 ? 64'sd2147483647 : q;
	endfunction

	function automatic longint akima_slope(output logic zero);
		longint n1, n0, num;
		zero = segz[0] | segz[1] | segz[2] | segz_old;
		n1 = seg[0] - seg[1];
		n1 = n1 < 0 ? -n1 : n1;
		n0 = seg[2] - seg_old;
		n0 = n0 < 0 ? -n0 : n0;
		if (n0 > eps_q || n1 > eps_q) begin
			while ((n0 | n1) >= 64'sd2147483648) begin
				n0 = n0 >>> 1;
				n1 = n1 >>> 1;
			end
			num = n1 * seg[2] + n0 * seg[1];
			return num / (n0 + n1);
		end
		return (seg[1] + seg[2]) / 2;
	endfunction

	function automatic longint older_knot_slope(int count, output logic zero);
		if (count == 2) begin
			zero = segz[1];
			return seg[1];
		end
		if (count == 3 || mode_q) return sat_div(ky[1] - ky[3], kx[1] - kx[3], zero);
		return akima_slope(zero);
	endfunction

	task automatic push_slope(longint s, logic last, logic zero);
		slope_item_t e;
		e.slope = s[31:0];
		e.last  = last;
		e.zero  = zero;
		expected_slopes.push_back(e);
	endtask

	task automatic take_knot(longint x, longint y, logic fin);
		longint s, new_seg;
		logic   z;
		int     c;
		c = knot_count;
		new_seg = 0;
		z = 1'b0;
		if (c >= 1) new_seg = sat_div(y - ky[0], x - kx[0], z);
		seg_old = seg[2];
		segz_old = segz[2];
		for (int i = 3; i > 0; i--) begin
			kx[i] = kx[i-1];
			ky[i] = ky[i-1];
		end
		kx[0] = x;
		ky[0] = y;
		for (int i = 2; i > 0; i--) begin
			seg[i] = seg[i-1];
			segz[i] = segz[i-1];
		end
		seg[0] = new_seg;
		segz[0] = z;
		if (!fin) begin
			if (c >= 2) begin
				s = older_knot_slope(c, z);
				push_slope(s, 1'b0, z);
			end
			knot_count = c < 4 ? c + 1 : 4;
			return;
		end
		knot_count = 0;
		if (c == 0) begin
			push_slope(0, 1'b1, 1'b0);
			return;
		end
		if (c >= 2) begin
			s = older_knot_slope(c, z);
			push_slope(s, 1'b0, z);
			s = sat_div(ky[0] - ky[2], kx[0] - kx[2], z);
			push_slope(s, 1'b0, z);
		end else begin
			push_slope(seg[0], 1'b0, segz[0]);
		end
		push_slope(seg[0], 1'b1, segz[0]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		slope_item_t e;
		if (!arst_n) begin
			mode_q <= 1'b0;
			eps_q <= 16'd1;
			for (int i = 0; i < 4; i++) begin
				kx[i] = 0;
				ky[i] = 0;
			end
			for (int i = 0; i < 3; i++) begin
				seg[i] = 0;
				segz[i] = 1'b0;
			end
			seg_old = 0;
			segz_old = 1'b0;
			knot_count = 0;
			fail_count <= 0;
			slopes_seen <= 0;
			expected_slopes.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_MODE) mode_q <= cfg_data[0];
				else if (cfg_index == CFG_EPS) eps_q <= cfg_data;
			end
			if (s_tvalid && s_tready)
				take_knot(longint'($signed(s_tdata[31:0])), longint'($signed(s_tdata[63:32])),
					s_tlast);
			if (m_tvalid && m_tready) begin
				slopes_seen <= slopes_seen + 1;
				if (expected_slopes.size() == 0) begin
					$error("slope item with nothing expected: %h", m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_slopes.pop_front();
					if (e.slope !== m_tdata || e.last !== m_tlast || e.zero !== m_tuser)
						fail_count <= fail_count + 1;
					if (e.slope !== m_tdata)
						$error("knot_slope: expected %h, got %h", e.slope, m_tdata);
					if (e.last !== m_tlast)
						$error("curve_end: expected %b, got %b", e.last, m_tlast);
					if (e.zero !== m_tuser)
						$error("zero_interval: expected %b, got %b", e.zero, m_tuser);
				end
			end
		end
		pending <= expected_slopes.size();
	end
endmodule
`default_nettype wire

/* test/tb.sv */
// testbench top for akima_knot_slopes: drives knots and register writes
// depends on akks_pkg, akima_knot_slopes and akks_checker
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import akks_pkg::*;

	localparam int LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid, s_tready, s_tlast;
	logic [63:0] s_tdata;
	logic        m_tvalid, m_tready, m_tlast, m_tuser;
	logic [31:0] m_tdata;
	logic        cfg_valid, cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	int          fail_count, pending, slopes_seen, cycle_count;
	int          curves_sent;

	akima_knot_slopes u_dut (.*);
	akks_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver stall pattern: runs of ready and of stall
	initial begin
		int run;
		m_tready = 1'b0;
		forever begin
			run = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 12);
			repeat (run) @(posedge clk);
			m_tready <= ~m_tready;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAIL akima_knot_slopes");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	int burst_left = 0;

	task automatic send_knot(logic [31:0] x, logic [31:0] y, logic fin);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 20);
			burst_left = $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {y, x};
		s_tlast <= fin;
		do @(posedge clk); while (!s_tready);
		if (fin) curves_sent++;
	endtask

	// a curve: x steps forward by random amounts and may wrap around, random y
	task automatic send_curve(int n, bit wide);
		logic [31:0] x;
		x = wide ? 32'h8000_0000 + $urandom_range(0, 1000) : $urandom;
		for (int i = 0; i < n; i++) begin
			send_knot(x, wide ? $urandom : $urandom_range(0, 32'h0004_0000) - 32'h2_0000,
				i == n - 1);
			case ($urandom_range(0, 5))
				0: x = x + 1;
				1: x = x + 32'h3fff_ffff;
				default: x = x + $urandom_range(1, 32'h0008_0000);
			endcase
		end
	endtask

	initial begin
		int n;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_MODE;
		cfg_data = '0;
		cycle_count = 0;
		curves_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: lone knot, two and three knot curves, equal x, extremes
		send_knot(32'h0001_0000, 32'h7fff_ffff, 1'b1);
		send_knot(32'h0000_0000, 32'h0000_0000, 1'b0);
		send_knot(32'h0001_0000, 32'h0002_0000, 1'b1);
		send_knot(32'h8000_0000, 32'h8000_0000, 1'b0);
		send_knot(32'h8000_0000, 32'h7fff_ffff, 1'b0);
		send_knot(32'h7fff_ffff, 32'h8000_0000, 1'b1);
		send_knot(32'h0000_1000, 32'h0000_0000, 1'b0);
		send_knot(32'h0000_1000, 32'h0000_0000, 1'b0);
		send_knot(32'h0000_2000, 32'hffff_0000, 1'b0);
		send_knot(32'h0000_2000, 32'h0001_0000, 1'b0);
		send_knot(32'h0000_3000, 32'hffff_ffff, 1'b0);
		send_knot(32'h0000_4000, 32'h0000_0001, 1'b1);
		// collinear knots keep both weights small: plain average
		for (int i = 0; i < 6; i++)
			send_knot(32'h0001_0000 * i, 32'h0002_0000 * i, i == 5);
		drain();

		write_reg(CFG_MODE, 16'd1);
		write_reg(CFG_EPS, 16'hffff);
		send_curve(6, 1'b0);
		drain();
		write_reg(CFG_MODE, 16'd0);
		send_curve(7, 1'b0);
		drain();
		write_reg(CFG_EPS, 16'd0);

		for (int k = 0; k < 80;) begin
			n = $urandom_range(0, 7) == 0 ? $urandom_range(1, 3) : $urandom_range(4, 9);
			send_curve(n, $urandom_range(0, 3) == 0);
			k += n;
			if ($urandom_range(0, 5) == 0) begin
				drain();
				write_reg(CFG_MODE, 16'($urandom_range(0, 1)));
				write_reg(CFG_EPS, $urandom_range(0, 3) == 0 ? 16'hffff : 16'($urandom));
			end
		end
		drain();

		$display("covered %0d curves and %0d slope items in both slope modes",
			curves_sent, slopes_seen);
		if (fail_count == 0) begin
			$display("PASS akima_knot_slopes");
		end else begin
			$display("FAIL akima_knot_slopes");
		end
		$finish;
	end
endmodule
`default_nettype wire

/* filelist.f */
src/akks_pkg.sv
src/akks_div.sv
src/akks_dp.sv
src/akks_ctrl.sv
src/akima_knot_slopes.sv
src/akks_chk.sv
test/akks_checker.sv
test/tb.sv
